/* sv/fca_pkg.sv */
`default_nettype none

package fca_pkg;

  // table geometry
  localparam int MAX_SECTORS = 65536;
  localparam int ADDR_W      = $clog2(MAX_SECTORS);
  localparam int CNT_W       = ADDR_W + 1;

  // link value that marks the end of a chain
  localparam logic [CNT_W-1:0] LINK_END = CNT_W'(MAX_SECTORS);
  // free count never rises above the addressable sector count
  localparam logic [CNT_W-1:0] FREE_MAX = CNT_W'(MAX_SECTORS);

  // configuration register indexes
  localparam logic REG_SECTOR_COUNT = 1'b0;
  localparam logic REG_RESERVED     = 1'b1;

  // request kinds
  localparam logic [2:0] KIND_FORMAT    = 3'd0;
  localparam logic [2:0] KIND_ALLOCATE  = 3'd1;
  localparam logic [2:0] KIND_TRUNCATE  = 3'd2;
  localparam logic [2:0] KIND_FREE      = 3'd3;
  localparam logic [2:0] KIND_FOLLOW    = 3'd4;
  localparam logic [2:0] KIND_FIND_LAST = 3'd5;

  // one table entry: free bit and next link
  typedef struct packed {
    logic             free;
    logic [CNT_W-1:0] link;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT,       // clearing pass after reset
    S_IDLE,
    S_FORMAT,     // format sweep
    S_ALLOC,      // scan for the sector to take
    S_ALNEXT,     // scan for the next free sector
    S_TAIL,       // link new sector after the tail
    S_CUTFIRST,   // end-mark the chain head
    S_CUTWALK,    // free the rest of the chain
    S_FREEFIRST,  // free the chain head
    S_FOLLOW,
    S_FINDLAST,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/fat_chain_allocator.sv */
`default_nettype none

// File allocation table engine. Every sector has an entry holding a next link
// (or the end mark) and a free bit, kept in one single-port table memory with a
// registered read; a next-fit pointer and a free count sit beside it. Requests
// arrive on the kind/sector/link_to_tail word and each gives exactly one result
// word (sector_out, is_end, status, free_count). The block takes one request at
// a time: in_ready is high only while the sequencer is idle, and a finished
// result may wait in the output register while the next request is taken.
// The one table port sets the pace: every entry visited is read, then acted on
// and written back. Allocate on an empty free count, and truncate, free,
// follow or find last on a sector out of range, go straight to the result. A
// result word is loaded only once the previous one has been taken on out_ready.
// Format rewrites all 65536 entries, one per cycle. After reset a clearing pass
// sets every entry to free with an end mark before in_ready first rises;
// configuration writes are taken at any time, but should only be issued while
// the block is idle.
// sector_count is clamped to 1..65536; links at or above it count as chain
// ends, and walks stop after that many steps so a cyclic chain cannot hang.
// Allocate with no free sector answers status 1 and changes nothing.

module fat_chain_allocator (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [fca_pkg::CNT_W-1:0] cfg_data,
  // request channel
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [2:0]             kind,
  input  wire logic [fca_pkg::ADDR_W-1:0] sector,
  input  wire logic                   link_to_tail,
  // result channel
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [fca_pkg::ADDR_W-1:0] sector_out,
  output      logic                   is_end,
  output      logic                   status,
  output      logic [fca_pkg::CNT_W-1:0] free_count
);
  import fca_pkg::*;

  // config registers
  logic [CNT_W-1:0]  sector_count;
  logic [ADDR_W-1:0] reserved_sectors;

  // control state
  state_t            state, state_next;
  logic              pend, pend_next;           // read of cur in flight
  logic [CNT_W-1:0]  cur, cur_next;             // walk position, sweep index
  logic [CNT_W-1:0]  steps, steps_next;
  logic [ADDR_W-1:0] alloc_pointer, alloc_pointer_next;
  logic [CNT_W-1:0]  free_total, free_total_next;
  logic              out_valid_next;

  // request and result held for the whole request
  logic [2:0]        kind_r, kind_r_next;
  logic [ADDR_W-1:0] sec_r, sec_r_next;
  logic              tail_r, tail_r_next;
  logic [ADDR_W-1:0] res, res_next;
  logic              end_r, end_r_next;
  logic              full_r, full_r_next;
  logic              load_out;

  // table memory
  entry_t            table_mem [MAX_SECTORS];
  entry_t            rd_entry;
  logic              mem_we;
  entry_t            mem_wdata;

  // shared step logic
  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  cur_plus;
  logic [CNT_W-1:0]  cur_wrap;
  logic [CNT_W-1:0]  steps_plus;
  logic [CNT_W-1:0]  sec_ext;
  logic              sec_in_range;
  logic              in_sec_in_range;
  logic              tail_ok;
  logic              rsv_over;
  logic              sweep_last;
  logic [CNT_W-1:0]  free_inc;

  // effective sector count, 1..MAX_SECTORS
  always_comb begin
    if (sector_count > CNT_W'(MAX_SECTORS)) begin
      eff = CNT_W'(MAX_SECTORS);
    end else if (sector_count == '0) begin
      eff = CNT_W'(1);
    end else begin
      eff = sector_count;
    end
  end

  assign cur_plus        = cur + CNT_W'(1);
  assign cur_wrap        = (cur_plus >= eff) ? '0 : cur_plus;
  assign steps_plus      = steps + CNT_W'(1);
  assign sec_ext         = {1'b0, sec_r};
  assign sec_in_range    = sec_ext < eff;
  assign in_sec_in_range = {1'b0, sector} < eff;
  assign tail_ok         = tail_r && sec_in_range && (sec_r != res);
  assign rsv_over        = {1'b0, reserved_sectors} >= eff;
  assign sweep_last      = &cur[ADDR_W-1:0];
  assign free_inc        = (free_total < FREE_MAX) ? free_total + CNT_W'(1) : free_total;

  assign in_ready = (state == S_IDLE);

  // table port: read every cycle at cur, write back in the act cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[cur[ADDR_W-1:0]] <= mem_wdata;
    end
    rd_entry <= table_mem[cur[ADDR_W-1:0]];
  end

  always_comb begin
    state_next         = state;
    pend_next          = pend;
    cur_next           = cur;
    steps_next         = steps;
    alloc_pointer_next = alloc_pointer;
    free_total_next    = free_total;
    kind_r_next        = kind_r;
    sec_r_next         = sec_r;
    tail_r_next        = tail_r;
    res_next           = res;
    end_r_next         = end_r;
    full_r_next        = full_r;
    out_valid_next     = out_valid;
    load_out           = 1'b0;
    mem_we             = 1'b0;
    mem_wdata          = '{free: 1'b1, link: LINK_END};

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          state_next = S_IDLE;
        end else begin
          cur_next = cur_plus;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_r_next = kind;
          sec_r_next  = sector;
          tail_r_next = link_to_tail;
          res_next    = '0;
          end_r_next  = 1'b0;
          full_r_next = 1'b0;
          pend_next   = 1'b1;
          steps_next  = '0;
          cur_next    = {1'b0, sector};
          case (kind)
            KIND_FORMAT: begin
              cur_next   = '0;
              state_next = S_FORMAT;
            end
            KIND_ALLOCATE: begin
              cur_next = ({1'b0, alloc_pointer} < eff) ? {1'b0, alloc_pointer} : '0;
              if (free_total == '0) begin
                full_r_next = 1'b1;
                state_next  = S_DONE;
              end else begin
                state_next = S_ALLOC;
              end
            end
            KIND_TRUNCATE, KIND_FREE: begin
              state_next = in_sec_in_range ? S_CUTFIRST : S_DONE;
            end
            KIND_FOLLOW: begin
              end_r_next = !in_sec_in_range;
              state_next = in_sec_in_range ? S_FOLLOW : S_DONE;
            end
            KIND_FIND_LAST: begin
              res_next   = sector;
              state_next = in_sec_in_range ? S_FINDLAST : S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_FORMAT: begin
        mem_we         = 1'b1;
        mem_wdata.free = cur[ADDR_W-1:0] >= reserved_sectors;
        if (sweep_last) begin
          free_total_next    = rsv_over ? '0 : eff - {1'b0, reserved_sectors};
          alloc_pointer_next = rsv_over ? '0 : reserved_sectors;
          state_next         = S_DONE;
        end else begin
          cur_next = cur_plus;
        end
      end

      S_ALLOC: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          pend_next = 1'b1;
          if (rd_entry.free) begin
            mem_we             = 1'b1;
            mem_wdata          = '{free: 1'b0, link: LINK_END};
            free_total_next    = (free_total != '0) ? free_total - CNT_W'(1) : free_total;
            res_next           = cur[ADDR_W-1:0];
            alloc_pointer_next = cur[ADDR_W-1:0];
            cur_next           = cur_wrap;
            steps_next         = CNT_W'(1);
            state_next         = S_ALNEXT;
          end else if (steps_plus == eff) begin
            full_r_next = 1'b1;
            state_next  = S_DONE;
          end else begin
            steps_next = steps_plus;
            cur_next   = cur_wrap;
          end
        end
      end

      S_ALNEXT: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          pend_next = 1'b1;
          if (steps == eff || rd_entry.free || steps_plus == eff) begin
            if (steps != eff && rd_entry.free) begin
              alloc_pointer_next = cur[ADDR_W-1:0];
            end
            cur_next   = sec_ext;
            state_next = tail_ok ? S_TAIL : S_DONE;
          end else begin
            steps_next = steps_plus;
            cur_next   = cur_wrap;
          end
        end
      end

      S_TAIL: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = '{free: rd_entry.free, link: {1'b0, res}};
          state_next = S_DONE;
        end
      end

      S_CUTFIRST: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          pend_next  = 1'b1;
          mem_we     = 1'b1;
          mem_wdata  = '{free: rd_entry.free, link: LINK_END};
          cur_next   = rd_entry.link;
          steps_next = '0;
          state_next = S_CUTWALK;
        end
      end

      S_CUTWALK: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          pend_next = 1'b1;
          if (steps == eff || cur >= eff) begin
            cur_next   = sec_ext;
            state_next = (kind_r == KIND_FREE) ? S_FREEFIRST : S_DONE;
          end else begin
            mem_we = 1'b1;
            if (!rd_entry.free) begin
              free_total_next = free_inc;
            end
            cur_next   = rd_entry.link;
            steps_next = steps_plus;
          end
        end
      end

      S_FREEFIRST: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          mem_we = 1'b1;
          if (!rd_entry.free) begin
            free_total_next = free_inc;
          end
          state_next = S_DONE;
        end
      end

      S_FOLLOW: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          if (rd_entry.link < eff) begin
            res_next = rd_entry.link[ADDR_W-1:0];
          end else begin
            end_r_next = 1'b1;
          end
          state_next = S_DONE;
        end
      end

      S_FINDLAST: begin
        if (pend) begin
          pend_next = 1'b0;
        end else begin
          pend_next = 1'b1;
          if (steps == eff || rd_entry.link >= eff) begin
            res_next   = cur[ADDR_W-1:0];
            state_next = S_DONE;
          end else begin
            cur_next   = rd_entry.link;
            steps_next = steps_plus;
          end
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_INIT;
      pend             <= 1'b0;
      cur              <= '0;
      steps            <= '0;
      alloc_pointer    <= '0;
      free_total       <= '0;
      out_valid        <= 1'b0;
      sector_count     <= CNT_W'(MAX_SECTORS);
      reserved_sectors <= '0;
    end else begin
      state         <= state_next;
      pend          <= pend_next;
      cur           <= cur_next;
      steps         <= steps_next;
      alloc_pointer <= alloc_pointer_next;
      free_total    <= free_total_next;
      out_valid     <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_SECTOR_COUNT: sector_count     <= cfg_data;
          REG_RESERVED:     reserved_sectors <= cfg_data[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_r_next;
    sec_r  <= sec_r_next;
    tail_r <= tail_r_next;
    res    <= res_next;
    end_r  <= end_r_next;
    full_r <= full_r_next;
    if (load_out) begin
      sector_out <= res;
      is_end     <= end_r;
      status     <= full_r;
      free_count <= free_total;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_fat_chain_allocator.sv */
`timescale 1ns / 100ps

import fca_pkg::*;

// one result word as it leaves the block
typedef struct packed {
  logic [15:0] sector_out;
  logic        is_end;
  logic        status;
  logic [16:0] free_count;
} fat_answer_t;

// Shadow copy of the allocation table: predicts the answer to every accepted
// request and checks the answers in order.
class fat_shadow;
  logic [CNT_W-1:0] links [MAX_SECTORS];
  bit               free_bit [MAX_SECTORS];
  int unsigned      ptr;
  int unsigned      free_total;
  int unsigned      sector_count;
  int unsigned      reserved;
  fat_answer_t      pending [$];
  int unsigned      recent [$];   // sectors handed out lately, for stimulus
  int               failures;

  function new();
    for (int n = 0; n < MAX_SECTORS; n++) begin
      links[n] = LINK_END;
      free_bit[n] = 1'b1;
    end
    ptr = 0;
    free_total = 0;
    sector_count = 65536;
    reserved = 0;
    failures = 0;
  endfunction

  function void set_reg(logic idx, int unsigned v);
    if (idx == REG_SECTOR_COUNT) sector_count = v & 32'h1FFFF;
    else reserved = v & 32'hFFFF;
  endfunction

  function int unsigned eff_count();
    int unsigned n;
    n = sector_count;
    if (n > MAX_SECTORS) n = MAX_SECTORS;
    if (n > 65536) n = 65536;
    if (n < 1) n = 1;
    return n;
  endfunction

  function int unsigned wrap_next(int unsigned v, int unsigned e);
    return (v + 1 >= e) ? 0 : v + 1;
  endfunction

  function void give_back(int unsigned s);
    if (!free_bit[s]) begin
      free_bit[s] = 1'b1;
      if (free_total < 65536) free_total++;
    end
  endfunction

  // end the chain at first, freeing everything behind it
  function void cut_after(int unsigned first, int unsigned e);
    int unsigned cur, nxt;
    cur = links[first];
    links[first] = LINK_END;
    for (int unsigned n = 0; n < e; n++) begin
      if (cur >= e) break;
      nxt = links[cur];
      links[cur] = LINK_END;
      give_back(cur);
      cur = nxt;
    end
  endfunction

  function void note_request(logic [2:0] k, logic [15:0] s_in, bit tail);
    int unsigned e, s, cur, nxt, p;
    bit          found;
    fat_answer_t a;
    e = eff_count();
    s = s_in;
    a = '0;
    case (k)
      KIND_FORMAT: begin
        for (int unsigned n = 0; n < MAX_SECTORS; n++) begin
          links[n] = LINK_END;
          free_bit[n] = (n >= reserved);
        end
        free_total = (reserved >= e) ? 0 : e - reserved;
        ptr = (reserved >= e) ? 0 : reserved;
        recent.delete();
      end
      KIND_ALLOCATE: begin
        cur = (ptr < e) ? ptr : 0;
        found = 1'b0;
        if (free_total != 0) begin
          for (int unsigned n = 0; n < e; n++) begin
            if (free_bit[cur]) begin
              found = 1'b1;
              break;
            end
            cur = wrap_next(cur, e);
          end
        end
        if (!found) begin
          a.status = 1'b1;
        end else begin
          free_bit[cur] = 1'b0;
          links[cur] = LINK_END;
          if (free_total > 0) free_total--;
          ptr = cur;
          p = wrap_next(cur, e);
          for (int unsigned n = 1; n < e; n++) begin
            if (free_bit[p]) begin
              ptr = p;
              break;
            end
            p = wrap_next(p, e);
          end
          if (tail && s < e && s != cur) links[s] = cur;
          a.sector_out = cur[15:0];
          recent.push_back(cur);
          if (recent.size() > 48) void'(recent.pop_front());
        end
      end
      KIND_TRUNCATE, KIND_FREE: begin
        if (s < e) begin
          cut_after(s, e);
          if (k == KIND_FREE) begin
            links[s] = LINK_END;
            give_back(s);
          end
        end
      end
      KIND_FOLLOW: begin
        if (s < e && links[s] < e) a.sector_out = links[s][15:0];
        else a.is_end = 1'b1;
      end
      KIND_FIND_LAST: begin
        cur = s;
        if (s < e) begin
          for (int unsigned n = 0; n < e; n++) begin
            nxt = links[cur];
            if (nxt >= e) break;
            cur = nxt;
          end
        end
        a.sector_out = cur[15:0];
      end
      default: ;
    endcase
    a.free_count = free_total[16:0];
    pending.push_back(a);
  endfunction

  function void check_answer(fat_answer_t got);
    fat_answer_t want;
    if (pending.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result word with none expected: sector %0d end %0b status %0b free %0d",
                 $realtime, got.sector_out, got.is_end, got.status, got.free_count);
      return;
    end
    want = pending.pop_front();
    if (got.sector_out !== want.sector_out || got.is_end !== want.is_end ||
        got.status !== want.status || got.free_count !== want.free_count) begin
      failures++;
      if (failures <= 10)
        $display("%0t: mismatch: sector %0d/%0d end %0b/%0b status %0b/%0b free %0d/%0d (exp/got)",
                 $realtime, want.sector_out, got.sector_out, want.is_end, got.is_end,
                 want.status, got.status, want.free_count, got.free_count);
    end
  endfunction
endclass

module tb_fat_chain_allocator;

  // kinds the block must ignore
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // quiet time after the last word; covers any trailing activity
  localparam int QUIET_CYCLES = 200;
  // roughly four times the slowest legal run (clearing pass, six formats, long
  // scans with stalls)
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_write = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CNT_W-1:0]    cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          kind = KIND_FORMAT;
  logic [ADDR_W-1:0]   sector = '0;
  logic                link_to_tail = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   sector_out;
  logic                is_end;
  logic                status;
  logic [CNT_W-1:0]    free_count;

  // high during the stretch where neither side idles
  bit steady = 1'b0;

  fat_shadow shadow;

  fat_chain_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .sector       (sector),
    .link_to_tail (link_to_tail),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sector_out   (sector_out),
    .is_end       (is_end),
    .status       (status),
    .free_count   (free_count)
  );

  always #6 clk = ~clk;

  // result side: stalls about 23% of cycles, none during the steady stretch
  always @(negedge clk) begin
    out_ready = steady ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // every result word taken at a rising edge goes to the checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_answer(fat_answer_t'({sector_out, is_end, status, free_count}));
  end

  // One request word. Random gaps go in front of it; valid then holds until
  // the block takes it, and stays up if the next word follows straight on.
  task automatic send_request(input logic [2:0] k, input int unsigned s, input bit l);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    sector = s[15:0];
    link_to_tail = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_request(k, s[15:0], l);
  endtask

  // hold off the request side until every result word is back
  task automatic wait_all_answered();
    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only ever called with the block idle
  task automatic load_geometry(input int unsigned count, input int unsigned resv);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_SECTOR_COUNT;
    cfg_data = count[16:0];
    @(negedge clk);
    cfg_index = REG_RESERVED;
    cfg_data = resv[16:0];
    @(negedge clk);
    cfg_write = 1'b0;
    shadow.set_reg(REG_SECTOR_COUNT, count);
    shadow.set_reg(REG_RESERVED, resv);
  endtask

  // Random traffic on the current table. Sectors mostly come from recent
  // allocations so chains get built, walked, cut and freed; the rest hit the
  // next-fit pointer, the live range edge, or anywhere in the address space.
  // No format here: a format sweeps the whole table.
  task automatic random_requests(input int n);
    int unsigned e, span, r, s;
    logic [2:0]  k;
    bit          l;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_all_answered();
      steady = (i >= n / 4) && (i < n / 4 + n / 5);
      e = shadow.eff_count();
      span = (e + 4 > 65536) ? 65536 : e + 4;
      r = $urandom_range(99);
      if (r < 35) k = KIND_ALLOCATE;
      else if (r < 50) k = KIND_FOLLOW;
      else if (r < 65) k = KIND_FIND_LAST;
      else if (r < 77) k = KIND_TRUNCATE;
      else if (r < 95) k = KIND_FREE;
      else if (r < 98) k = KIND_SPARE_A;
      else k = KIND_SPARE_B;
      r = $urandom_range(99);
      if (r < 45 && shadow.recent.size() > 0)
        s = shadow.recent[$urandom_range(shadow.recent.size() - 1)];
      else if (r < 55) s = shadow.ptr;
      else if (r < 88) s = $urandom_range(span - 1);
      else s = $urandom_range(16'hFFFF);
      l = ($urandom_range(3) != 0);
      send_request(k, s, l);
    end
    steady = 1'b0;
  endtask

  initial begin
    shadow = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry, table not formatted: free count is zero so allocate
    // must say full; all links are end marks
    send_request(KIND_ALLOCATE, 0, 1'b1);
    send_request(KIND_FOLLOW, 0, 1'b0);
    send_request(KIND_FIND_LAST, 16'hFFFF, 1'b0);
    send_request(KIND_SPARE_A, 16'hFFFF, 1'b1);
    send_request(KIND_SPARE_B, 16'h5A5A, 1'b0);
    // full-size format, then build 0 -> 1 -> 2 and take it apart
    send_request(KIND_FORMAT, 0, 1'b0);
    send_request(KIND_ALLOCATE, 0, 1'b0);
    send_request(KIND_ALLOCATE, 0, 1'b1);
    send_request(KIND_ALLOCATE, 1, 1'b1);
    send_request(KIND_FOLLOW, 0, 1'b0);
    send_request(KIND_FIND_LAST, 0, 1'b0);
    send_request(KIND_FOLLOW, 2, 1'b0);
    send_request(KIND_TRUNCATE, 0, 1'b0);
    send_request(KIND_FREE, 0, 1'b0);
    // freeing an already free sector must not move the count
    send_request(KIND_FREE, 0, 1'b0);
    random_requests(250);
    wait_all_answered();

    // small table with a reserved head
    load_geometry(16, 3);
    send_request(KIND_FORMAT, 0, 1'b0);
    // sectors past the end of the table
    send_request(KIND_FOLLOW, 20, 1'b0);
    send_request(KIND_FIND_LAST, 20, 1'b0);
    send_request(KIND_TRUNCATE, 16, 1'b0);
    send_request(KIND_FREE, 16, 1'b0);
    // tail out of range: no link made
    send_request(KIND_ALLOCATE, 16, 1'b1);
    // tail equal to the sector handed out: no self link
    send_request(KIND_ALLOCATE, 4, 1'b1);
    send_request(KIND_FOLLOW, 3, 1'b0);
    random_requests(300);
    wait_all_answered();

    // count of zero clamps to one sector, reserved beyond it: nothing free
    load_geometry(0, 5);
    send_request(KIND_FORMAT, 0, 1'b0);
    send_request(KIND_ALLOCATE, 0, 1'b1);
    send_request(KIND_FIND_LAST, 0, 1'b0);
    wait_all_answered();

    // oversize count clamps to the full table, all but the top sector reserved
    load_geometry(17'h1FFFF, 65535);
    send_request(KIND_FORMAT, 0, 1'b0);
    send_request(KIND_ALLOCATE, 65535, 1'b1);
    send_request(KIND_ALLOCATE, 0, 1'b0);
    send_request(KIND_FREE, 65535, 1'b0);
    wait_all_answered();

    load_geometry(40, 0);
    send_request(KIND_FORMAT, 0, 1'b0);
    random_requests(350);
    wait_all_answered();

    // shrink without a format: old links and used sectors now lie beyond the
    // end, so stale links act as end marks and the count can disagree
    load_geometry(24, 70);
    random_requests(250);
    wait_all_answered();

    load_geometry(100, 10);
    send_request(KIND_FORMAT, 0, 1'b0);
    random_requests(420);
    wait_all_answered();

    repeat (QUIET_CYCLES) @(posedge clk);
    if (shadow.failures == 0 && shadow.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/fca_pkg.sv
sv/fat_chain_allocator.sv
dv/tb_fat_chain_allocator.sv
